[src/dbrd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dbrd_pkg;

  // Field widths
  localparam int OPCODE_W = 3;
  localparam int ID_W     = 16;
  localparam int VALUE_W  = 16;
  localparam int FREE_W   = 10;
  localparam int HDR_W    = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // Bitmap word geometry
  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_LOCAL_FLAG  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_LOCAL_VAR   = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_REMOTE_FLAG = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_REMOTE_VAR  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_DRAIN       = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FLAG_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VAR_BASE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HDR_COST   = 2'd2;

  // Reset values of the configuration registers
  localparam logic [ID_W-1:0]  FLAG_BASE_RST = 16'h0020;
  localparam logic [ID_W-1:0]  VAR_BASE_RST  = 16'h4000;
  localparam logic [HDR_W-1:0] HDR_COST_RST  = 4'd1;

  // Payload bytes of each report kind
  localparam logic [HDR_W:0] FLAG_PAYLOAD = 5'd2;
  localparam logic [HDR_W:0] VAR_PAYLOAD  = 5'd4;

  // Report kinds
  localparam logic KIND_FLAG = 1'b0;
  localparam logic KIND_VAR  = 1'b1;

endpackage

`default_nettype wire

[src/dbrd_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Command channel: writes and drain ticks
interface dbrd_in_if
  import dbrd_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [ID_W-1:0]     item_id;
  logic [VALUE_W-1:0]  write_value;
  logic                online;
  logic [FREE_W-1:0]   free_bytes;

  modport source (output valid, opcode, item_id, write_value, online, free_bytes,
                  input ready);
  modport sink (input valid, opcode, item_id, write_value, online, free_bytes,
                output ready);
endinterface

// Report channel
interface dbrd_out_if
  import dbrd_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic               report_kind;
  logic [ID_W-1:0]    report_id;
  logic [VALUE_W-1:0] report_value;
  logic               last_report;

  modport source (output valid, report_kind, report_id, report_value, last_report,
                  input ready);
  modport sink (input valid, report_kind, report_id, report_value, last_report,
                output ready);
endinterface

`default_nettype wire

[src/dirty_bitmap_report_drain.sv]
// Dirty-bitmap write tracker. Online local flag and variable writes inside the
// two id windows set a dirty bit; every in-window variable write also updates
// the value store. An online drain tick with bits dirty walks the flag bitmap,
// then the variable bitmap, one 32-bit word at a time through that bitmap's
// read-modify-write port, and sends one report per dirty id while ring space
// and the burst cap allow. After reset the block zeroes both bitmaps, one word
// a cycle, over max(ceil(FLAG_WINDOW/32), ceil(VAR_WINDOW/32)) words (75 at
// the defaults) before it takes the first command. A write command passes
// through decode, and when it sets a dirty bit also a word read and a word
// write. A drain tick decodes, then reads, loads, scans and writes back each
// bitmap word, with one scan step per flag report and a scan step plus a value
// read per variable report; the word loop sets the length of a pass, and a
// full report register on the output adds stalls.
`timescale 1ns / 1ps
`default_nettype none

module dirty_bitmap_report_drain
  import dbrd_pkg::*;
#(
  parameter int FLAG_WINDOW = 2400,
  parameter int VAR_WINDOW  = 256,
  parameter int MAX_BURST   = 32
) (
  input  wire                   clk,
  input  wire                   rst,
  dbrd_in_if.sink               cmd,
  dbrd_out_if.source            report,
  input  wire                   cfg_we,
  input  wire [CFG_IDX_W-1:0]   cfg_index,
  input  wire [CFG_DATA_W-1:0]  cfg_data
);

  localparam int FLAG_WORDS = (FLAG_WINDOW + WORD_W - 1) / WORD_W;
  localparam int VAR_WORDS  = (VAR_WINDOW + WORD_W - 1) / WORD_W;
  localparam int FAW = (FLAG_WORDS > 1) ? $clog2(FLAG_WORDS) : 1;
  localparam int VAW = (VAR_WORDS > 1) ? $clog2(VAR_WORDS) : 1;
  localparam int WIW = (FAW > VAW) ? FAW : VAW;
  localparam int VOW = $clog2(VAR_WINDOW);
  localparam int NW  = $clog2(MAX_BURST + 1);
  localparam int CLR_WORDS = (FLAG_WORDS > VAR_WORDS) ? FLAG_WORDS : VAR_WORDS;

  localparam logic [WIW:0]   FW_CNT    = (WIW + 1)'(FLAG_WORDS);
  localparam logic [WIW:0]   VW_CNT    = (WIW + 1)'(VAR_WORDS);
  localparam logic [WIW-1:0] FW_LAST   = WIW'(FLAG_WORDS - 1);
  localparam logic [WIW-1:0] VW_LAST   = WIW'(VAR_WORDS - 1);
  localparam logic [WIW-1:0] CLR_LAST  = WIW'(CLR_WORDS - 1);
  localparam logic [ID_W:0]  FWIN      = (ID_W + 1)'(FLAG_WINDOW);
  localparam logic [ID_W:0]  VWIN      = (ID_W + 1)'(VAR_WINDOW);
  localparam logic [NW-1:0]  BURST_CAP = NW'(MAX_BURST);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DEC, S_OPRD, S_OPWR,
    S_DRD, S_DLOAD, S_DSCAN, S_DVAL, S_DWB, S_DEND
  } state_t;

  state_t state;

  // Configuration
  logic [ID_W-1:0]  flag_base;
  logic [ID_W-1:0]  var_base;
  logic [HDR_W-1:0] hdr_cost;

  // Latched command
  logic [OPCODE_W-1:0] i_op;
  logic [ID_W-1:0]     i_id;
  logic [VALUE_W-1:0]  i_val;
  logic                i_online;
  logic [FREE_W-1:0]   i_free;

  // Write-op target
  logic              op_var;
  logic [WIW-1:0]    op_word;
  logic [BIT_W-1:0]  op_bit;

  // Drain walk
  logic              any_dirty;
  logic              phase;
  logic              stop;
  logic [WIW-1:0]    widx;
  logic [WIW-1:0]    clr_idx;
  logic [WORD_W-1:0] cur_word;
  logic [FREE_W-1:0] budget;
  logic [NW-1:0]     sent;

  // Held report, waiting to learn whether it is the last one
  logic               pend_valid;
  logic               pend_kind;
  logic [ID_W-1:0]    pend_id;
  logic [VALUE_W-1:0] pend_value;

  // Output register
  logic               out_valid;
  logic               out_kind;
  logic [ID_W-1:0]    out_id;
  logic [VALUE_W-1:0] out_value;
  logic               out_last;

  // Memories
  logic [WORD_W-1:0]  flag_mem [FLAG_WORDS];
  logic [WORD_W-1:0]  vdirty_mem [VAR_WORDS];
  logic [VALUE_W-1:0] val_mem [VAR_WINDOW];
  logic [WORD_W-1:0]  flag_rdata;
  logic [WORD_W-1:0]  vdirty_rdata;
  logic [VALUE_W-1:0] val_rdata;

  logic              f_we;
  logic [FAW-1:0]    f_waddr;
  logic [FAW-1:0]    f_raddr;
  logic [WORD_W-1:0] f_wdata;
  logic              vd_we;
  logic [VAW-1:0]    vd_waddr;
  logic [VAW-1:0]    vd_raddr;
  logic [WORD_W-1:0] vd_wdata;
  logic              v_we;
  logic [VOW-1:0]    v_waddr;
  logic [VOW-1:0]    v_raddr;

  // Window checks on the latched id
  logic [ID_W:0]     flag_diff;
  logic [ID_W:0]     var_diff;
  logic              f_in;
  logic              v_in;

  // Scan helpers
  logic [BIT_W-1:0]  hit_bit;
  logic [ID_W-1:0]   scan_off;
  logic [HDR_W:0]    cost;
  logic [WORD_W-1:0] op_rmw;

  assign flag_diff = {1'b0, i_id} - {1'b0, flag_base};
  assign var_diff  = {1'b0, i_id} - {1'b0, var_base};
  assign f_in      = !flag_diff[ID_W] && (flag_diff < FWIN);
  assign v_in      = !var_diff[ID_W] && (var_diff < VWIN);

  // Find the lowest dirty bit of the current word
  always_comb begin
    hit_bit = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (cur_word[b]) begin
        hit_bit = BIT_W'(b);
      end
    end
  end

  assign scan_off = ID_W'({widx, hit_bit});
  assign cost     = {1'b0, hdr_cost} + (phase ? VAR_PAYLOAD : FLAG_PAYLOAD);
  assign op_rmw   = (op_var ? vdirty_rdata : flag_rdata) | (WORD_W'(1) << op_bit);

  // Bitmap port control
  always_comb begin
    f_we     = 1'b0;
    f_waddr  = widx[FAW-1:0];
    f_wdata  = cur_word;
    vd_we    = 1'b0;
    vd_waddr = widx[VAW-1:0];
    vd_wdata = cur_word;
    case (state)
      S_CLEAR: begin
        f_we     = {1'b0, clr_idx} < FW_CNT;
        f_waddr  = clr_idx[FAW-1:0];
        f_wdata  = '0;
        vd_we    = {1'b0, clr_idx} < VW_CNT;
        vd_waddr = clr_idx[VAW-1:0];
        vd_wdata = '0;
      end
      S_OPWR: begin
        f_we     = !op_var;
        f_waddr  = op_word[FAW-1:0];
        f_wdata  = op_rmw;
        vd_we    = op_var;
        vd_waddr = op_word[VAW-1:0];
        vd_wdata = op_rmw;
      end
      S_DWB: begin
        f_we  = !phase;
        vd_we = phase;
      end
      default: begin
      end
    endcase
  end

  assign f_raddr  = (state == S_OPRD) ? op_word[FAW-1:0] : widx[FAW-1:0];
  assign vd_raddr = (state == S_OPRD) ? op_word[VAW-1:0] : widx[VAW-1:0];

  // Value store port control
  assign v_we    = (state == S_DEC) && v_in &&
                   ((i_op == OP_LOCAL_VAR) || (i_op == OP_REMOTE_VAR));
  assign v_waddr = VOW'(var_diff[ID_W-1:0]);
  assign v_raddr = VOW'({widx, hit_bit});

  // Flag bitmap memory
  always_ff @(posedge clk) begin
    if (f_we) begin
      flag_mem[f_waddr] <= f_wdata;
    end
    flag_rdata <= flag_mem[f_raddr];
  end

  // Variable bitmap memory
  always_ff @(posedge clk) begin
    if (vd_we) begin
      vdirty_mem[vd_waddr] <= vd_wdata;
    end
    vdirty_rdata <= vdirty_mem[vd_raddr];
  end

  // Variable value store
  always_ff @(posedge clk) begin
    if (v_we) begin
      val_mem[v_waddr] <= i_val;
    end
    val_rdata <= val_mem[v_raddr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      any_dirty  <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      flag_base  <= FLAG_BASE_RST;
      var_base   <= VAR_BASE_RST;
      hdr_cost   <= HDR_COST_RST;
    end else begin
      // Configuration writes
      if (cfg_we) begin
        case (cfg_index)
          REG_FLAG_BASE: flag_base <= cfg_data[ID_W-1:0];
          REG_VAR_BASE:  var_base  <= cfg_data[ID_W-1:0];
          REG_HDR_COST:  hdr_cost  <= cfg_data[HDR_W-1:0];
          default: begin
          end
        endcase
      end

      // Drop the report once it is taken
      if (out_valid && report.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == CLR_LAST) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (cmd.valid) begin
            i_op     <= cmd.opcode;
            i_id     <= cmd.item_id;
            i_val    <= cmd.write_value;
            i_online <= cmd.online;
            i_free   <= cmd.free_bytes;
            state    <= S_DEC;
          end
        end

        S_DEC: begin
          state <= S_IDLE;
          case (i_op)
            OP_LOCAL_FLAG: begin
              if (i_online && f_in) begin
                op_var    <= 1'b0;
                op_word   <= WIW'(flag_diff[ID_W-1:0] >> BIT_W);
                op_bit    <= flag_diff[BIT_W-1:0];
                any_dirty <= 1'b1;
                state     <= S_OPRD;
              end
            end
            OP_LOCAL_VAR: begin
              if (i_online && v_in) begin
                op_var    <= 1'b1;
                op_word   <= WIW'(var_diff[ID_W-1:0] >> BIT_W);
                op_bit    <= var_diff[BIT_W-1:0];
                any_dirty <= 1'b1;
                state     <= S_OPRD;
              end
            end
            OP_REMOTE_FLAG, OP_REMOTE_VAR: begin
            end
            OP_DRAIN: begin
              if (any_dirty && i_online) begin
                budget <= i_free;
                sent   <= '0;
                phase  <= 1'b0;
                stop   <= 1'b0;
                widx   <= '0;
                state  <= S_DRD;
              end
            end
            default: begin
            end
          endcase
        end

        // Word read in flight; the modified word is written next
        S_OPRD: state <= S_OPWR;
        S_OPWR: state <= S_IDLE;

        S_DRD: state <= S_DLOAD;

        S_DLOAD: begin
          cur_word <= phase ? vdirty_rdata : flag_rdata;
          state    <= S_DSCAN;
        end

        S_DSCAN: begin
          if (cur_word == '0) begin
            state <= S_DWB;
          end else if ((sent == BURST_CAP) || (budget < FREE_W'(cost))) begin
            stop  <= 1'b1;
            state <= S_DWB;
          end else if (!pend_valid || !out_valid) begin
            // Push the held report out and hold the new one
            if (pend_valid) begin
              out_valid <= 1'b1;
              out_kind  <= pend_kind;
              out_id    <= pend_id;
              out_value <= pend_value;
              out_last  <= 1'b0;
            end
            cur_word   <= cur_word & ~(WORD_W'(1) << hit_bit);
            budget     <= budget - FREE_W'(cost);
            sent       <= sent + 1'b1;
            pend_kind  <= phase;
            pend_id    <= (phase ? var_base : flag_base) + scan_off;
            pend_value <= '0;
            if (phase) begin
              pend_valid <= 1'b0;
              state      <= S_DVAL;
            end else begin
              pend_valid <= 1'b1;
            end
          end
        end

        S_DVAL: begin
          pend_value <= val_rdata;
          pend_valid <= 1'b1;
          state      <= S_DSCAN;
        end

        // Word written back; advance to the next word or window, or end the pass
        S_DWB: begin
          if (stop) begin
            state <= S_DEND;
          end else if (!phase && (widx == FW_LAST)) begin
            phase <= 1'b1;
            widx  <= '0;
            state <= S_DRD;
          end else if (phase && (widx == VW_LAST)) begin
            state <= S_DEND;
          end else begin
            widx  <= widx + 1'b1;
            state <= S_DRD;
          end
        end

        S_DEND: begin
          if (!pend_valid) begin
            if (!stop) begin
              any_dirty <= 1'b0;
            end
            state <= S_IDLE;
          end else if (!out_valid) begin
            out_valid  <= 1'b1;
            out_kind   <= pend_kind;
            out_id     <= pend_id;
            out_value  <= pend_value;
            out_last   <= 1'b1;
            pend_valid <= 1'b0;
            if (!stop) begin
              any_dirty <= 1'b0;
            end
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign cmd.ready           = (state == S_IDLE);
  assign report.valid        = out_valid;
  assign report.report_kind  = out_kind;
  assign report.report_id    = out_id;
  assign report.report_value = out_value;
  assign report.last_report  = out_last;

endmodule

`default_nettype wire

[verif/dirty_bitmap_report_drain_tb.sv]
`timescale 1ns / 1ps

module dirty_bitmap_report_drain_tb;
  import dbrd_pkg::*;

  localparam int FLAG_WIN  = 2400;
  localparam int VAR_WIN   = 256;
  localparam int BURST_CAP = 32;

  // A drain pass walks every bitmap word and output stalls add to it; leave plenty.
  localparam int QUIET_CYCLES   = 600;
  localparam int CHOKE_CYCLES   = 1200;
  localparam int WATCHDOG_LIMIT = 6000;

  // Opcodes past the drain tick are reserved and ignored by the block.
  localparam logic [OPCODE_W-1:0] OP_RSVD_FIRST = OP_DRAIN + 1'b1;
  localparam logic [OPCODE_W-1:0] OP_RSVD_LAST  = '1;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [ID_W-1:0]     item_id;
    logic [VALUE_W-1:0]  write_value;
    logic                online;
    logic [FREE_W-1:0]   free_bytes;
  } cmd_t;

  typedef struct packed {
    logic               kind;
    logic [ID_W-1:0]    id;
    logic [VALUE_W-1:0] value;
    logic               last;
  } report_t;

  logic clk;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dbrd_in_if  cmd_ch ();
  dbrd_out_if report_ch ();

  dirty_bitmap_report_drain #(
    .FLAG_WINDOW (FLAG_WIN),
    .VAR_WINDOW  (VAR_WIN),
    .MAX_BURST   (BURST_CAP)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .report    (report_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Tracker state as the block should hold it
  logic [ID_W-1:0]    flag_base;
  logic [ID_W-1:0]    var_base;
  logic [HDR_W-1:0]   hdr_cost;
  bit                 flag_dirty [FLAG_WIN];
  bit                 var_dirty [VAR_WIN];
  logic [VALUE_W-1:0] var_value [VAR_WIN];
  bit                 dirty_pending;

  cmd_t    queued_cmds[$];
  report_t pending_reports[$];
  int      fail_count;
  bit      calm;
  bit      choke_on;

  always #2 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic bit in_range(logic [ID_W-1:0] id, logic [ID_W-1:0] base,
                                  int unsigned size, output int unsigned off);
    off = 0;
    if (id < base) return 0;
    off = 32'(id) - 32'(base);
    return off < size;
  endfunction

  // Walk flags then variables, emitting reports while room and burst cap allow
  function automatic void predict_drain(logic [FREE_W-1:0] free);
    report_t     batch[$];
    report_t     r;
    int unsigned room;
    int unsigned fcost;
    int unsigned vcost;
    bit          complete;
    room     = 32'(free);
    fcost    = 32'(hdr_cost) + 32'(FLAG_PAYLOAD);
    vcost    = 32'(hdr_cost) + 32'(VAR_PAYLOAD);
    complete = 1'b1;
    for (int i = 0; i < FLAG_WIN && complete; i++) begin
      if (flag_dirty[i]) begin
        if (batch.size() >= BURST_CAP || room < fcost) begin
          complete = 1'b0;
        end else begin
          r.kind  = KIND_FLAG;
          r.id    = flag_base + 16'(i);
          r.value = '0;
          r.last  = 1'b0;
          batch.push_back(r);
          room -= fcost;
          flag_dirty[i] = 1'b0;
        end
      end
    end
    for (int i = 0; i < VAR_WIN && complete; i++) begin
      if (var_dirty[i]) begin
        if (batch.size() >= BURST_CAP || room < vcost) begin
          complete = 1'b0;
        end else begin
          r.kind  = KIND_VAR;
          r.id    = var_base + 16'(i);
          r.value = var_value[i];
          r.last  = 1'b0;
          batch.push_back(r);
          room -= vcost;
          var_dirty[i] = 1'b0;
        end
      end
    end
    if (complete) dirty_pending = 1'b0;
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[k]) pending_reports.push_back(batch[k]);
  endfunction

  function automatic void track_command(cmd_t c);
    int unsigned off;
    bit          hit;
    case (c.opcode)
      OP_LOCAL_FLAG: begin
        hit = in_range(c.item_id, flag_base, FLAG_WIN, off);
        if (hit && c.online) begin
          flag_dirty[off] = 1'b1;
          dirty_pending   = 1'b1;
        end
      end
      OP_LOCAL_VAR: begin
        hit = in_range(c.item_id, var_base, VAR_WIN, off);
        if (hit) begin
          var_value[off] = c.write_value;
          if (c.online) begin
            var_dirty[off] = 1'b1;
            dirty_pending  = 1'b1;
          end
        end
      end
      OP_REMOTE_VAR: begin
        hit = in_range(c.item_id, var_base, VAR_WIN, off);
        if (hit) var_value[off] = c.write_value;
      end
      OP_DRAIN: begin
        if (dirty_pending && c.online) predict_drain(c.free_bytes);
      end
      default: ;
    endcase
  endfunction

  // Driver: hold each item until accepted, then idle a random gap
  cmd_t        held_cmd;
  bit          drv_busy;
  int unsigned drv_gap;

  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      drv_gap = 0;
    end else begin
      drv_busy = cmd_ch.valid;
      if (cmd_ch.valid && cmd_ch.ready) begin
        track_command(held_cmd);
        drv_busy = 1'b0;
      end
      if (!drv_busy) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (queued_cmds.size() > 0) begin
          held_cmd = queued_cmds.pop_front();
          drv_busy = 1'b1;
          cmd_ch.opcode      <= held_cmd.opcode;
          cmd_ch.item_id     <= held_cmd.item_id;
          cmd_ch.write_value <= held_cmd.write_value;
          cmd_ch.online      <= held_cmd.online;
          cmd_ch.free_bytes  <= held_cmd.free_bytes;
          drv_gap = pick_gap();
        end
      end
      cmd_ch.valid <= drv_busy;
    end
  end

  // Monitor: check each accepted report and stall the output at random or while choked
  int unsigned rx_stall;
  int unsigned choke_count;
  report_t     seen;
  report_t     want;

  always @(posedge clk) begin
    if (rst) begin
      report_ch.ready <= 1'b0;
      rx_stall    = 0;
      choke_count = 0;
    end else begin
      if (report_ch.valid && report_ch.ready) begin
        seen.kind  = report_ch.report_kind;
        seen.id    = report_ch.report_id;
        seen.value = report_ch.report_value;
        seen.last  = report_ch.last_report;
        if (pending_reports.size() == 0) begin
          $error("report with none pending: kind %0d id %0h value %0h last %0d",
                 seen.kind, seen.id, seen.value, seen.last);
          fail_count++;
        end else begin
          want = pending_reports.pop_front();
          if (seen.kind !== want.kind) begin
            $error("report_kind: expected %0d, got %0d", want.kind, seen.kind);
            fail_count++;
          end
          if (seen.id !== want.id) begin
            $error("report_id: expected %0h, got %0h", want.id, seen.id);
            fail_count++;
          end
          if (seen.value !== want.value) begin
            $error("report_value: expected %0h, got %0h", want.value, seen.value);
            fail_count++;
          end
          if (seen.last !== want.last) begin
            $error("last_report: expected %0d, got %0d", want.last, seen.last);
            fail_count++;
          end
        end
      end
      if (choke_on && choke_count < CHOKE_CYCLES) begin
        choke_count++;
        report_ch.ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        report_ch.ready <= 1'b0;
      end else begin
        report_ch.ready <= 1'b1;
        rx_stall = pick_gap();
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  int unsigned stuck_cycles;

  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (report_ch.valid && report_ch.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  function automatic void push_cmd(logic [OPCODE_W-1:0] op, logic [ID_W-1:0] id,
                                   logic [VALUE_W-1:0] val, logic on,
                                   logic [FREE_W-1:0] free);
    cmd_t c;
    c.opcode      = op;
    c.item_id     = id;
    c.write_value = val;
    c.online      = on;
    c.free_bytes  = free;
    queued_cmds.push_back(c);
  endfunction

  function automatic cmd_t random_write();
    cmd_t        c;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    c.opcode = (sel < 40) ? OP_LOCAL_FLAG :
               (sel < 75) ? OP_LOCAL_VAR :
               (sel < 90) ? OP_REMOTE_VAR : OP_REMOTE_FLAG;
    if ($urandom_range(0, 9) == 0) begin
      c.item_id = 16'($urandom);
    end else if (c.opcode == OP_LOCAL_FLAG || c.opcode == OP_REMOTE_FLAG) begin
      c.item_id = flag_base + 16'($urandom_range(0, FLAG_WIN - 1));
    end else if ($urandom_range(0, 1) == 0) begin
      // crowd the first 32 variables so they get rewritten between drains
      c.item_id = var_base + 16'($urandom_range(0, 31));
    end else begin
      c.item_id = var_base + 16'($urandom_range(0, VAR_WIN - 1));
    end
    c.write_value = 16'($urandom);
    c.online      = ($urandom_range(0, 9) != 0);
    c.free_bytes  = 10'($urandom);
    return c;
  endfunction

  function automatic cmd_t random_drain();
    cmd_t        c;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    c.opcode      = OP_DRAIN;
    c.item_id     = 16'($urandom);
    c.write_value = 16'($urandom);
    c.online      = ($urandom_range(0, 7) != 0);
    c.free_bytes  = (sel < 55) ? 10'($urandom_range(64, 1023)) :
                    (sel < 80) ? 10'($urandom_range(0, 40)) : 10'($urandom_range(0, 1023));
    return c;
  endfunction

  // Mostly write bursts closed by a drain tick, the rest raw noise
  task automatic random_items(int n);
    int   made;
    int   k;
    cmd_t c;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 99) < 65) begin
        k = $urandom_range(1, 6);
        repeat (k) queued_cmds.push_back(random_write());
        queued_cmds.push_back(random_drain());
        made += k + 1;
      end else begin
        c.opcode      = 3'($urandom_range(0, OP_RSVD_LAST));
        c.item_id     = 16'($urandom);
        c.write_value = 16'($urandom);
        c.online      = 1'($urandom_range(0, 1));
        c.free_bytes  = 10'($urandom);
        queued_cmds.push_back(c);
        if (c.opcode <= OP_DRAIN) made++;
      end
    end
  endtask

  // Wait until every item is taken and every report is in, then let the block settle
  task automatic wait_quiet();
    do @(posedge clk);
    while (queued_cmds.size() != 0 || cmd_ch.valid || pending_reports.size() != 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic apply_regs(logic [ID_W-1:0] fb, logic [ID_W-1:0] vb, logic [HDR_W-1:0] hc);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FLAG_BASE;
    cfg_data  <= fb;
    flag_base = fb;
    @(posedge clk);
    cfg_index <= REG_VAR_BASE;
    cfg_data  <= vb;
    var_base = vb;
    @(posedge clk);
    cfg_index <= REG_HDR_COST;
    cfg_data  <= CFG_DATA_W'(hc);
    hdr_cost = hc;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [ID_W-1:0] fb;
    logic [ID_W-1:0] vb;
    clk = 1'b0;
    rst = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    cmd_ch.valid       = 1'b0;
    cmd_ch.opcode      = '0;
    cmd_ch.item_id     = '0;
    cmd_ch.write_value = '0;
    cmd_ch.online      = 1'b0;
    cmd_ch.free_bytes  = '0;
    report_ch.ready    = 1'b0;
    flag_base     = FLAG_BASE_RST;
    var_base      = VAR_BASE_RST;
    hdr_cost      = HDR_COST_RST;
    dirty_pending = 1'b0;
    fail_count    = 0;
    calm          = 1'b0;
    choke_on      = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    wait_quiet();

    // Directed: window edges, offline writes, ignored opcodes, partial drains
    apply_regs(FLAG_BASE_RST, VAR_BASE_RST, HDR_COST_RST);
    fb = FLAG_BASE_RST;
    vb = VAR_BASE_RST;
    push_cmd(OP_LOCAL_FLAG, fb, 16'h0000, 1'b1, 10'h000);
    push_cmd(OP_LOCAL_FLAG, fb + 16'(FLAG_WIN - 1), 16'hFFFF, 1'b1, 10'h3FF);
    push_cmd(OP_LOCAL_FLAG, fb - 16'd1, 16'h0000, 1'b1, 10'h000);
    push_cmd(OP_LOCAL_FLAG, fb + 16'(FLAG_WIN), 16'h0000, 1'b1, 10'h000);
    push_cmd(OP_LOCAL_FLAG, fb + 16'd100, 16'h0000, 1'b0, 10'h000);
    push_cmd(OP_REMOTE_FLAG, fb + 16'd200, 16'h0000, 1'b1, 10'h000);
    push_cmd(OP_LOCAL_FLAG, 16'h0000, 16'h0000, 1'b1, 10'h000);
    push_cmd(OP_LOCAL_VAR, vb, 16'hFFFF, 1'b1, 10'h000);
    push_cmd(OP_LOCAL_VAR, vb + 16'(VAR_WIN - 1), 16'h0000, 1'b1, 10'h000);
    push_cmd(OP_LOCAL_VAR, vb + 16'(VAR_WIN), 16'h1234, 1'b1, 10'h000);
    push_cmd(OP_LOCAL_VAR, 16'hFFFF, 16'h1234, 1'b1, 10'h000);
    push_cmd(OP_LOCAL_VAR, vb + 16'd5, 16'h1234, 1'b0, 10'h000);
    push_cmd(OP_REMOTE_VAR, vb + 16'(VAR_WIN - 1), 16'hA5A5, 1'b1, 10'h000);
    for (int op = OP_RSVD_FIRST; op <= OP_RSVD_LAST; op++)
      push_cmd(OP_RSVD_FIRST + 3'(op - OP_RSVD_FIRST), fb, 16'hFFFF, 1'b1, 10'h3FF);
    push_cmd(OP_DRAIN, 16'h0000, 16'h0000, 1'b0, 10'h3FF);
    push_cmd(OP_DRAIN, 16'h0000, 16'h0000, 1'b1, 10'h000);
    push_cmd(OP_DRAIN, 16'h0000, 16'h0000, 1'b1, 10'd6);
    push_cmd(OP_DRAIN, 16'h0000, 16'h0000, 1'b1, 10'd9);
    push_cmd(OP_DRAIN, 16'h0000, 16'h0000, 1'b1, 10'h3FF);
    push_cmd(OP_DRAIN, 16'h0000, 16'h0000, 1'b1, 10'h3FF);
    push_cmd(OP_LOCAL_VAR, vb + 16'd5, 16'h8001, 1'b1, 10'h000);
    push_cmd(OP_REMOTE_VAR, vb + 16'd5, 16'h7FFE, 1'b1, 10'h000);
    push_cmd(OP_DRAIN, 16'h0000, 16'h0000, 1'b1, 10'h3FF);
    wait_quiet();

    // Overfill the burst cap while the output is held off, so the input stalls
    apply_regs(16'h0000, 16'h0000, 4'h0);
    choke_on = 1'b1;
    for (int k = 0; k < 36; k++)
      push_cmd(OP_LOCAL_FLAG, 16'(k * 60 + $urandom_range(0, 59)), 16'($urandom), 1'b1,
               10'($urandom));
    push_cmd(OP_LOCAL_VAR, 16'($urandom_range(0, VAR_WIN - 1)), 16'($urandom), 1'b1,
             10'h000);
    push_cmd(OP_LOCAL_VAR, 16'($urandom_range(0, VAR_WIN - 1)), 16'($urandom), 1'b1,
             10'h000);
    push_cmd(OP_DRAIN, 16'h0000, 16'h0000, 1'b1, 10'h3FF);
    repeat (3) push_cmd(OP_REMOTE_VAR, 16'($urandom_range(0, VAR_WIN - 1)), 16'($urandom),
                        1'b1, 10'h000);
    push_cmd(OP_DRAIN, 16'h0000, 16'h0000, 1'b1, 10'h3FF);
    wait_quiet();

    // Windows pushed to the top of the id space, largest header
    apply_regs(16'(17'h10000 - FLAG_WIN), 16'(17'h10000 - VAR_WIN), 4'hF);
    random_items(12);
    wait_quiet();

    // One-id windows at the very top; leftovers report under the new base
    apply_regs(16'hFFFF, 16'hFFFF, 4'h7);
    random_items(12);
    wait_quiet();

    // Random bases with no idling on either side
    calm = 1'b1;
    apply_regs(16'($urandom), 16'($urandom), 4'($urandom_range(0, 15)));
    random_items(12);
    wait_quiet();
    calm = 1'b0;

    apply_regs(FLAG_BASE_RST, VAR_BASE_RST, HDR_COST_RST);
    random_items(12);
    wait_quiet();

    if (fail_count == 0 && pending_reports.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
